### hw/rtl/p5td_pkg.sv
// Shared types, code points and character tables for the packed 5-bit text decoder.
package p5td_pkg;

	localparam int BYTES_PER_CHUNK = 5;
	localparam int CODE_W          = 5;
	localparam int CHUNK_W         = 8 * BYTES_PER_CHUNK;
	localparam int CODES_PER_CHUNK = CHUNK_W / CODE_W;
	localparam int CODE_IDX_W      = $clog2(CODES_PER_CHUNK);
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

	localparam logic [CODE_IDX_W-1:0] LAST_CODE_IDX = CODE_IDX_W'(CODES_PER_CHUNK - 1);

	localparam logic [CODE_W-1:0] CODE_STOP    = 5'h00;
	localparam logic [CODE_W-1:0] CODE_CAPITAL = 5'h1e;
	localparam logic [CODE_W-1:0] CODE_SYMBOL  = 5'h1f;

	localparam logic [6:0] CASE_OFFSET   = 7'h20;
	localparam logic [6:0] ASCII_SPACE   = 7'h20;
	localparam logic [6:0] CAPITAL_SPACE = 7'h40;
	localparam logic [6:0] END_CHAR      = 7'h00;

	localparam logic [6:0] LETTER_TABLE [32] = '{
		7'h2e, 7'h2e, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
		7'h67, 7'h68, 7'h69, 7'h6a, 7'h6b, 7'h6c, 7'h6d, 7'h6e,
		7'h6f, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76,
		7'h77, 7'h78, 7'h79, 7'h7a, 7'h20, 7'h2e, 7'h00, 7'h00
	};

	localparam logic [6:0] SYMBOL_TABLE [32] = '{
		7'h5b, 7'h5d, 7'h0a, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25,
		7'h26, 7'h27, 7'h28, 7'h29, 7'h2c, 7'h2d, 7'h2f, 7'h30,
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h3a, 7'h3b, 7'h3f, 7'h3c, 7'h3e, 7'h00, 7'h00
	};

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic               term;
	} chunk_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DECODE,
		BK_END
	} back_state_t;

	function automatic logic [6:0] map_code(input logic [CODE_W-1:0] code,
	                                        input logic cap, input logic sym);
		logic [6:0] ch;
		ch = LETTER_TABLE[code];
		if (sym) begin
			return SYMBOL_TABLE[code];
		end
		if (cap && ch == ASCII_SPACE) begin
			return CAPITAL_SPACE;
		end
		if (cap) begin
			return ch - CASE_OFFSET;
		end
		return ch;
	endfunction

endpackage

### hw/rtl/p5td_front.sv
// Front end: gathers encoded bytes into 40-bit chunks and pads the chunk at the terminator.
module p5td_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        encoded_byte,
	output logic              push,
	output p5td_pkg::chunk_t  push_data,
	input  logic              queue_ready
);
	import p5td_pkg::*;

	logic [31:0] bytes_q;
	logic [2:0]  count_q;
	logic        accept;
	logic        is_term;
	logic [CHUNK_W-1:0] padded;

	assign in_ready = queue_ready;
	assign accept   = in_valid && in_ready;
	assign is_term  = (encoded_byte == 8'h00);
	assign push     = accept && (is_term || count_q == 3'd4);

	always_comb begin
		case (count_q)
			3'd1:    padded = {bytes_q[7:0], 32'h0};
			3'd2:    padded = {bytes_q[15:0], 24'h0};
			3'd3:    padded = {bytes_q[23:0], 16'h0};
			3'd4:    padded = {bytes_q, 8'h0};
			default: padded = '0;
		endcase
	end

	always_comb begin
		push_data.term  = is_term;
		push_data.chunk = is_term ? padded : {bytes_q, encoded_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (push) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !push) begin
			bytes_q <= {bytes_q[23:0], encoded_byte};
		end
	end

endmodule

### hw/rtl/p5td_queue.sv
// Short chunk queue between the front end and the decoder.
module p5td_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  p5td_pkg::chunk_t push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output p5td_pkg::chunk_t pop_data
);
	import p5td_pkg::*;

	chunk_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/p5td_back.sv
// Back end: walks a chunk one 5-bit code per cycle unless its output register stalls.
module p5td_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  p5td_pkg::chunk_t q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [6:0]       char_code,
	output logic             end_of_string
);
	import p5td_pkg::*;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [CHUNK_W-1:0]    chunk_q;
	logic                  term_q;
	logic [CODE_IDX_W-1:0] idx_q;
	logic                  cap_q;
	logic                  sym_q;
	logic                  stop_q;
	logic                  out_valid_q;
	logic [6:0]            char_q;
	logic                  eos_q;

	logic              advance;
	logic [CODE_W-1:0] code;
	logic              step;
	logic              emit_char;
	logic              emit_eos;
	logic              set_stop;
	logic              set_cap;
	logic              set_sym;

	assign advance = !out_valid_q || out_ready;
	assign code    = chunk_q[CHUNK_W-1 -: CODE_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (!stop_q) begin
						state_d = BK_DECODE;
					end else if (q_data.term) begin
						state_d = BK_END;
					end
				end
			end
			BK_DECODE: begin
				if (advance && (code == CODE_STOP || idx_q == LAST_CODE_IDX)) begin
					state_d = term_q ? BK_END : BK_IDLE;
				end
			end
			BK_END: begin
				if (advance) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		step      = 1'b0;
		emit_char = 1'b0;
		emit_eos  = 1'b0;
		set_stop  = 1'b0;
		set_cap   = 1'b0;
		set_sym   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
			end
			BK_DECODE: begin
				step      = advance;
				set_stop  = advance && code == CODE_STOP;
				set_cap   = advance && code == CODE_CAPITAL;
				set_sym   = advance && code == CODE_SYMBOL;
				emit_char = advance && code != CODE_STOP && code != CODE_CAPITAL &&
				            code != CODE_SYMBOL;
			end
			BK_END: begin
				emit_eos = advance;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			cap_q       <= 1'b0;
			sym_q       <= 1'b0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit_eos) begin
				cap_q  <= 1'b0;
				sym_q  <= 1'b0;
				stop_q <= 1'b0;
			end else begin
				if (emit_char) begin
					cap_q <= 1'b0;
					sym_q <= 1'b0;
				end
				if (set_cap) begin
					cap_q <= 1'b1;
				end
				if (set_sym) begin
					sym_q <= 1'b1;
				end
				if (set_stop) begin
					stop_q <= 1'b1;
				end
			end
			if (emit_char || emit_eos) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			chunk_q <= q_data.chunk;
			term_q  <= q_data.term;
		end else if (step) begin
			chunk_q <= {chunk_q[CHUNK_W-CODE_W-1:0], CODE_W'(0)};
		end
		if (emit_char) begin
			char_q <= map_code(code, cap_q, sym_q);
			eos_q  <= 1'b0;
		end else if (emit_eos) begin
			char_q <= END_CHAR;
			eos_q  <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_code     = char_q;
	assign end_of_string = eos_q;

endmodule

### hw/rtl/packed_5bit_text_decoder_core.sv
// Top level of the packed 5-bit text decoder: front end, chunk queue, decoder back end.
// Bytes are taken one per cycle while the two-entry chunk queue has room; every fifth byte,
// or the zero terminator, pushes a 40-bit chunk into the queue. The back end loads a chunk
// from the queue in its idle state, then decodes its 5-bit codes, up to eight, one per cycle
// while the output register can advance, and after the terminating chunk it emits the end
// marker in its end state. A stop code ends a chunk early, and later chunks of the same string
// are dropped as they are popped. Results leave through a registered output stage, so bytes
// keep flowing into the queue while it has room and a result waits to be taken.
module packed_5bit_text_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] encoded_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_code,
	output logic       end_of_string
);
	import p5td_pkg::*;

	logic   push;
	chunk_t push_data;
	logic   queue_ready;
	logic   q_valid;
	logic   q_pop;
	chunk_t q_data;

	p5td_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.encoded_byte (encoded_byte),
		.push         (push),
		.push_data    (push_data),
		.queue_ready  (queue_ready)
	);

	p5td_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (queue_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_data)
	);

	p5td_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_code     (char_code),
		.end_of_string (end_of_string)
	);

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> queue_ready)
		else $error("chunk pushed into a full queue");

	a_end_marker_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_string |-> char_code == END_CHAR)
		else $error("end marker carries a character");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_string |-> char_code != END_CHAR)
		else $error("character item with zero code");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("decoder popped an empty queue");
`endif

endmodule

### tb/packed_5bit_text_decoder_core_tb.sv
// Self-checking testbench for the packed 5-bit text decoder core.
module packed_5bit_text_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import p5td_pkg::CODE_STOP;
	import p5td_pkg::CODE_CAPITAL;
	import p5td_pkg::CODE_SYMBOL;

	typedef struct {
		logic [7:0] value;
		int         gap;
	} byte_item_t;

	typedef struct {
		logic [6:0] ch;
		logic       eos;
	} char_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] encoded_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] char_code;
	logic       end_of_string;

	string letter_chars = "..abcdefghijklmnopqrstuvwxyz .";
	string symbol_chars = "[]\n!\"#$%&'(),-/0123456789:;?<>";

	byte_item_t pending_bytes[$];
	char_item_t expected_chars[$];
	byte_item_t next_item;

	logic [31:0] held_bytes = '0;
	int          held_count = 0;
	logic        capital_mark = 1'b0;
	logic        symbol_mark = 1'b0;
	logic        halted = 1'b0;

	int errors = 0;
	int bytes_queued = 0;
	int bytes_sent = 0;
	int strings_done = 0;
	int results_seen = 0;
	int gap_count = 0;
	int stall_count = 0;
	int stall_draw = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	packed_5bit_text_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.encoded_byte (encoded_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.end_of_string(end_of_string)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [6:0] code_to_ascii(input logic [4:0] code);
		logic [6:0] ch;
		if (symbol_mark) begin
			return 7'(symbol_chars[code]);
		end
		ch = 7'(letter_chars[code]);
		if (capital_mark) begin
			return (ch == 7'h20) ? 7'h40 : ch - 7'h20;
		end
		return ch;
	endfunction

	task automatic expand_chunk(input logic [39:0] chunk);
		logic [4:0] code;
		char_item_t res;
		int j;
		for (j = 0; j < 8; j++) begin
			code = chunk[39 - 5 * j -: 5];
			if (code == CODE_STOP) begin
				halted = 1'b1;
				break;
			end
			if (code == CODE_CAPITAL) begin
				capital_mark = 1'b1;
			end else if (code == CODE_SYMBOL) begin
				symbol_mark = 1'b1;
			end else begin
				res.ch = code_to_ascii(code);
				res.eos = 1'b0;
				expected_chars.push_back(res);
				capital_mark = 1'b0;
				symbol_mark = 1'b0;
			end
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [39:0] chunk;
		char_item_t res;
		if (b == 8'h00) begin
			if (!halted && held_count > 0) begin
				chunk = {8'h00, held_bytes} << (8 * (5 - held_count));
				expand_chunk(chunk);
			end
			res.ch = 7'h00;
			res.eos = 1'b1;
			expected_chars.push_back(res);
			held_bytes = '0;
			held_count = 0;
			capital_mark = 1'b0;
			symbol_mark = 1'b0;
			halted = 1'b0;
			strings_done++;
		end else if (!halted) begin
			if (held_count == 4) begin
				chunk = {held_bytes, b};
				held_bytes = '0;
				held_count = 0;
				expand_chunk(chunk);
			end else begin
				held_bytes = {held_bytes[23:0], b};
				held_count++;
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		byte_item_t item;
		if (bytes_queued % 60 == 0) begin
			in_quiet = ($urandom_range(0, 2) == 0);
		end
		item.value = b;
		item.gap = in_quiet ? 0 : $urandom_range(0, 6);
		pending_bytes.push_back(item);
		bytes_queued++;
	endtask

	task automatic push_chunk(input logic [39:0] chunk, input int nbytes);
		int k;
		for (k = 0; k < nbytes; k++) begin
			push_byte(chunk[39 - 8 * k -: 8]);
		end
	endtask

	function automatic logic [4:0] random_code(input bit stop_ok);
		int r;
		r = $urandom_range(0, 99);
		if (stop_ok && r < 3) begin
			return CODE_STOP;
		end
		if (r < 13) begin
			return CODE_CAPITAL;
		end
		if (r < 23) begin
			return CODE_SYMBOL;
		end
		return 5'($urandom_range(1, 29));
	endfunction

	function automatic logic [39:0] random_chunk(input bit stop_ok);
		logic [39:0] chunk;
		int j;
		for (j = 0; j < 8; j++) begin
			chunk[39 - 5 * j -: 5] = random_code(stop_ok);
		end
		return chunk;
	endfunction

	task automatic push_random_string();
		bit stop_ok;
		int nchunks;
		int k;
		if ($urandom_range(0, 99) < 75) begin
			stop_ok = ($urandom_range(0, 4) == 0);
			nchunks = $urandom_range(0, 3);
			for (k = 0; k < nchunks; k++) begin
				push_chunk(random_chunk(stop_ok), 5);
			end
			push_chunk(random_chunk(stop_ok), $urandom_range(0, 4));
		end else begin
			nchunks = $urandom_range(0, 12);
			for (k = 0; k < nchunks; k++) begin
				push_byte(8'($urandom_range(1, 255)));
			end
		end
		push_byte(8'h00);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			encoded_byte <= 8'h00;
			gap_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(encoded_byte);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_count < pending_bytes[0].gap) begin
					in_valid <= 1'b0;
					gap_count <= gap_count + 1;
				end else begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					encoded_byte <= next_item.value;
					gap_count <= 0;
				end
			end
		end
	end

	task automatic check_result();
		char_item_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch($sformatf("unexpected result char %h end %b",
				char_code, end_of_string));
		end else begin
			want = expected_chars.pop_front();
			if (char_code !== want.ch) begin
				report_mismatch($sformatf("result %0d char_code %h, want %h",
					results_seen, char_code, want.ch));
			end
			if (end_of_string !== want.eos) begin
				report_mismatch($sformatf("result %0d end_of_string %b, want %b",
					results_seen, end_of_string, want.eos));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_count <= 0;
		end else if (out_valid && out_ready) begin
			check_result();
			results_seen++;
			if (results_seen % 40 == 0) begin
				out_quiet = ($urandom_range(0, 2) == 0);
			end
			stall_draw = out_quiet ? 0 : $urandom_range(0, 6);
			if (stall_draw == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_count <= stall_draw - 1;
			end
		end else if (!out_ready) begin
			if (stall_count == 0) begin
				out_ready <= 1'b1;
			end else begin
				stall_count <= stall_count - 1;
			end
		end
	end

	initial begin
		push_byte(8'h00);
		push_chunk({CODE_CAPITAL, 5'd28, CODE_SYMBOL, 5'd3,
			CODE_CAPITAL, CODE_SYMBOL, 5'd29, 5'd27}, 5);
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(8'hff);
		push_byte(8'h00);
		push_chunk({5'd2, CODE_STOP, 5'd5, 5'd9, 5'd12, 5'd20, 5'd1, 5'd29}, 5);
		push_byte(8'h55);
		push_byte(8'haa);
		push_byte(8'h00);
		push_chunk({CODE_CAPITAL, 5'd2, 5'd28, CODE_CAPITAL,
			5'd1, CODE_CAPITAL, 5'd9, 5'd4}, 4);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'h00);
		while (bytes_queued < 440) begin
			push_random_string();
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_bytes.size() > 0 || in_valid || expected_chars.size() > 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);

		$display("Sent %0d bytes in %0d strings; compared %0d decoded results.",
			bytes_sent, strings_done, results_seen);
		if (errors == 0) begin
			$display("packed_5bit_text_decoder_core regression: pass");
		end else begin
			$display("packed_5bit_text_decoder_core regression: fail");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timed out with %0d results outstanding.", expected_chars.size());
		$display("packed_5bit_text_decoder_core regression: fail");
		$finish;
	end

endmodule

### files.f
hw/rtl/p5td_pkg.sv
hw/rtl/p5td_front.sv
hw/rtl/p5td_queue.sv
hw/rtl/p5td_back.sv
hw/rtl/packed_5bit_text_decoder_core.sv
tb/packed_5bit_text_decoder_core_tb.sv
